// ===== src/ita_pkg.sv =====
// Shared types and constants for the integer to ASCII digit converter.
package ita_pkg;

   // Conversion opcodes
   localparam logic [2:0] OPC_UDEC = 3'd0;
   localparam logic [2:0] OPC_SDEC = 3'd1;
   localparam logic [2:0] OPC_OCT  = 3'd2;
   localparam logic [2:0] OPC_HEXL = 3'd3;
   localparam logic [2:0] OPC_HEXU = 3'd4;

   // Length modes
   localparam logic [2:0] LEN_INT = 3'd0;
   localparam logic [2:0] LEN_HH  = 3'd1;
   localparam logic [2:0] LEN_H   = 3'd2;
   localparam logic [2:0] LEN_L   = 3'd3;
   localparam logic [2:0] LEN_LL  = 3'd4;

   localparam int OPC_W   = 3;
   localparam int LEN_W   = 3;
   localparam int DIGIT_W = 4;
   localparam int CHAR_W  = 7;
   localparam int OUT_COUNT_W = 32;

   localparam logic [CHAR_W-1:0] ASC_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] ASC_UPPER = 7'h41;
   localparam logic [CHAR_W-1:0] ASC_LOWER = 7'h61;
   localparam logic [DIGIT_W-1:0] DEC_BASE = 4'd10;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOAD   = 5'b00010,
      ST_DABBLE = 5'b00100,
      ST_SKIP   = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   typedef struct packed {
      logic capture;   // take the input item
      logic prep;      // cut, take magnitude, load digits
      logic dabble;    // one double-dabble step
      logic shift;     // drop a leading zero digit
      logic emit;      // move top digit to the output register
      logic last;      // digit being emitted is the final one
   } cmd_type;

   typedef struct packed {
      logic op_known;  // incoming opcode is a valid conversion
      logic is_dec;    // current item converts to decimal
      logic top_zero;  // most significant digit slot is zero
      logic out_free;  // output register can take a digit
   } sts_type;

endpackage

// ===== src/integer_to_ascii_digits.sv =====
// Top level of the integer to ASCII digit converter.
//
// Input channel req_: one item per number. req_tdata carries the raw operand,
// the conversion opcode and the length mode. Items with an unknown opcode are
// taken and dropped without results. Result channel rsp_: one item per ASCII
// digit, most significant first, rsp_tlast on the final digit, and the running
// character count beside each digit.
// Each item is taken, then the operand is cut and the digit register loaded;
// decimal items then run VALUE_WIDTH double-dabble steps (octal and hex none),
// leading zero slots of the (VALUE_WIDTH+2)/3-digit register are dropped down
// to one digit, and the digits are emitted one per cycle while the receiver
// keeps up. The double-dabble loop makes decimal items the longest.
// req_tready is high only between items. The last digit may still wait in the
// output register while the next item is taken.
// Reset clears the sequencer, the output valid flag and the character counter.
// A stalled receiver holds the current digit and pauses digit emission.
module integer_to_ascii_digits #(
   parameter int VALUE_WIDTH = 64,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // value, opcode[2:0], length_mode[2:0], zero fill
   input  logic [((VALUE_WIDTH+6+7)/8)*8-1:0]     req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // digit_char[6:0], chars_written[31:0], zero fill
   output logic [39:0]                            rsp_tdata,
   output logic                                   rsp_tlast
);
   import ita_pkg::*;

   cmd_type                 cmd;
   sts_type                 sts;
   logic [CHAR_W-1:0]       out_char;
   logic [OUT_COUNT_W-1:0]  out_count;

   ita_ctrl #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ita_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_value  (req_tdata[VALUE_WIDTH-1:0]),
      .req_opcode (req_tdata[VALUE_WIDTH +: OPC_W]),
      .req_length (req_tdata[VALUE_WIDTH+OPC_W +: LEN_W]),
      .rsp_tready (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_char   (out_char),
      .out_last   (rsp_tlast),
      .out_count  (out_count)
   );

   assign rsp_tdata = {1'b0, out_count, out_char};

endmodule

// ===== src/ita_ctrl.sv =====
// Sequencer for the integer to ASCII digit converter.
module ita_ctrl #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  ita_pkg::sts_type sts,
   output ita_pkg::cmd_type cmd
);
   import ita_pkg::*;

   localparam int NDIG = (VALUE_WIDTH + 2) / 3;
   localparam int BCW  = $clog2(VALUE_WIDTH);
   localparam int DCW  = $clog2(NDIG + 1);

   state_type      state_ff, state_in;
   logic [BCW-1:0] bit_ff, bit_in;
   logic [DCW-1:0] dig_ff, dig_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      bit_in     = bit_ff;
      dig_in     = dig_ff;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               // drop items with an unknown opcode
               if (sts.op_known) state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.prep = 1'b1;
            bit_in   = '0;
            dig_in   = DCW'(NDIG);
            state_in = sts.is_dec ? ST_DABBLE : ST_SKIP;
         end
         ST_DABBLE: begin
            cmd.dabble = 1'b1;
            bit_in     = bit_ff + 1'b1;
            if (bit_ff == BCW'(VALUE_WIDTH - 1)) state_in = ST_SKIP;
         end
         ST_SKIP: begin
            if (sts.top_zero && dig_ff != DCW'(1)) begin
               cmd.shift = 1'b1;
               dig_in    = dig_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.last = (dig_ff == DCW'(1));
               dig_in   = dig_ff - 1'b1;
               if (dig_ff == DCW'(1)) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bit_ff <= bit_in;
      dig_ff <= dig_in;
   end

endmodule

// ===== src/ita_dpath.sv =====
// Datapath: operand cut, magnitude, digit register, output register and counter.
module ita_dpath #(
   parameter int VALUE_WIDTH = 64,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ita_pkg::cmd_type                       cmd,
   output ita_pkg::sts_type                       sts,
   input  logic [VALUE_WIDTH-1:0]                 req_value,
   input  logic [ita_pkg::OPC_W-1:0]              req_opcode,
   input  logic [ita_pkg::LEN_W-1:0]              req_length,
   input  logic                                   rsp_tready,
   output logic                                   out_valid,
   output logic [ita_pkg::CHAR_W-1:0]             out_char,
   output logic                                   out_last,
   output logic [ita_pkg::OUT_COUNT_W-1:0]        out_count
);
   import ita_pkg::*;

   localparam int NDIG = (VALUE_WIDTH + 2) / 3;
   localparam int P3   = 3 * NDIG;
   localparam int P4   = 4 * NDIG;

   logic [VALUE_WIDTH-1:0] value_ff;
   logic [OPC_W-1:0]       op_ff;
   logic [LEN_W-1:0]       len_ff;

   logic [VALUE_WIDTH-1:0] x_ff, x_in;
   logic [DIGIT_W-1:0]     dig_ff [NDIG];
   logic [DIGIT_W-1:0]     dig_in [NDIG];
   logic [DIGIT_W-1:0]     adj    [NDIG];

   logic                   valid_ff, valid_in;
   logic [CHAR_W-1:0]      char_ff, char_in;
   logic                   last_ff, last_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;

   logic [VALUE_WIDTH-1:0] mask, xm, neg, mag;
   logic                   sign;
   logic [P3-1:0]          mag3;
   logic [P4-1:0]          mag4;
   logic [DIGIT_W-1:0]     top;
   logic [CHAR_W-1:0]      alpha, digit_char;

   assign sts.op_known = req_opcode inside {[OPC_UDEC:OPC_HEXU]};
   assign sts.is_dec   = (op_ff == OPC_UDEC) || (op_ff == OPC_SDEC);
   assign top          = dig_ff[NDIG-1];
   assign sts.top_zero = (top == '0);
   assign sts.out_free = !valid_ff || rsp_tready;

   // cut to the selected length and take the magnitude in signed mode
   always_comb begin
      case (len_ff)
         LEN_HH: begin
            mask = VALUE_WIDTH'({8{1'b1}});
            sign = value_ff[7];
         end
         LEN_H: begin
            mask = VALUE_WIDTH'({16{1'b1}});
            sign = value_ff[15];
         end
         LEN_L, LEN_LL: begin
            mask = '1;
            sign = value_ff[VALUE_WIDTH-1];
         end
         default: begin
            mask = VALUE_WIDTH'({32{1'b1}});
            sign = value_ff[31];
         end
      endcase
      xm  = value_ff & mask;
      neg = (~xm + 1'b1) & mask;
      mag = (op_ff == OPC_SDEC && sign) ? neg : xm;
   end

   assign mag3 = P3'(mag);
   assign mag4 = P4'(mag);

   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         adj[i] = (dig_ff[i] >= 4'd5) ? dig_ff[i] + 4'd3 : dig_ff[i];
      end
   end

   always_comb begin
      x_in = x_ff;
      for (int i = 0; i < NDIG; i++) dig_in[i] = dig_ff[i];
      if (cmd.prep) begin
         x_in = mag;
         for (int i = 0; i < NDIG; i++) begin
            if (op_ff == OPC_OCT)
               dig_in[i] = {1'b0, mag3[3*i +: 3]};
            else if (op_ff == OPC_HEXL || op_ff == OPC_HEXU)
               dig_in[i] = mag4[4*i +: 4];
            else
               dig_in[i] = '0;
         end
      end else if (cmd.dabble) begin
         // adjust every BCD digit, then shift the next operand bit in
         x_in      = {x_ff[VALUE_WIDTH-2:0], 1'b0};
         dig_in[0] = {adj[0][2:0], x_ff[VALUE_WIDTH-1]};
         for (int i = 1; i < NDIG; i++) dig_in[i] = {adj[i][2:0], adj[i-1][3]};
      end else if (cmd.shift || cmd.emit) begin
         dig_in[0] = '0;
         for (int i = 1; i < NDIG; i++) dig_in[i] = dig_ff[i-1];
      end
   end

   assign alpha      = (op_ff == OPC_HEXU) ? ASC_UPPER : ASC_LOWER;
   assign digit_char = (top < DEC_BASE) ? ASC_ZERO + CHAR_W'(top)
                                        : alpha + CHAR_W'(top) - CHAR_W'(DEC_BASE);

   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      cnt_in   = cnt_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         char_in  = digit_char;
         last_in  = cmd.last;
         cnt_in   = cnt_ff + 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
      if (cmd.capture) begin
         value_ff <= req_value;
         op_ff    <= req_opcode;
         len_ff   <= req_length;
      end
      x_ff    <= x_in;
      dig_ff  <= dig_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;
   assign out_count = OUT_COUNT_W'(cnt_ff);

endmodule

// ===== src/ita_checker.sv =====
// Port-level checks for the integer to ASCII digit converter, bound to the top.
module ita_checker #(
   parameter int VALUE_WIDTH = 64,
   parameter int COUNT_WIDTH = 32
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [((VALUE_WIDTH+6+7)/8)*8-1:0] req_tdata,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [39:0]                        rsp_tdata,
   input logic                               rsp_tlast
);
   import ita_pkg::*;

   logic [31:0] prev_ff;
   logic        seen_ff;
   logic [31:0] wrap_mask;
   logic [31:0] expect_cnt;
   logic        rsp_take;
   logic [2:0]  req_op;
   logic [6:0]  ch;

   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign req_op     = req_tdata[VALUE_WIDTH +: OPC_W];
   assign ch         = rsp_tdata[6:0];
   assign wrap_mask  = (COUNT_WIDTH >= 32) ? '1 : 32'((64'd1 << COUNT_WIDTH) - 64'd1);
   assign expect_cnt = (prev_ff + 32'd1) & wrap_mask;

   // track the count of the previous taken item
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_take) begin
         seen_ff <= 1'b1;
      end
      if (rsp_take) prev_ff <= rsp_tdata[38:7];
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_take && seen_ff |-> rsp_tdata[38:7] == expect_cnt)
      else $error("character count did not advance by one");

   a_drop: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_op > OPC_HEXU)
      |=> req_tready)
      else $error("unknown opcode item was not dropped");

   a_char: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (ch >= 7'h30 && ch <= 7'h39) || (ch >= 7'h41 && ch <= 7'h46)
                     || (ch >= 7'h61 && ch <= 7'h66))
      else $error("result is not a digit character");

endmodule

bind integer_to_ascii_digits ita_checker #(
   .VALUE_WIDTH (VALUE_WIDTH),
   .COUNT_WIDTH (COUNT_WIDTH)
) u_ita_checker (.*);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the integer to ASCII digit converter.
module tb_top;
   import ita_pkg::*;

   localparam int REQ_W          = ((64 + OPC_W + LEN_W + 7) / 8) * 8;
   localparam int RANDOM_NUMBERS = 205;
   localparam int CYCLE_LIMIT    = 2000000;
   localparam int SETTLE_CYCLES  = 200;

   // opcode and length codes outside the defined sets
   localparam logic [2:0] OPC_UNKNOWN_MAX = 3'd7;
   localparam logic [2:0] LEN_UNKNOWN_MIN = 3'd5;
   localparam logic [2:0] LEN_UNKNOWN_MAX = 3'd7;

   typedef struct {
      logic [63:0] value;
      logic [2:0]  opcode;
      logic [2:0]  len_mode;
      int          gap;
      bit          hold;
   } conv_item_type;

   typedef struct {
      logic [CHAR_W-1:0]      digit;
      logic                   last;
      logic [OUT_COUNT_W-1:0] count;
   } digit_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [39:0]      rsp_tdata;
   logic             rsp_tlast;

   conv_item_type          pending_numbers[$];
   digit_type              digits_due[$];
   logic [OUT_COUNT_W-1:0] char_total = '0;
   int unsigned            digits_predicted = 0;
   int unsigned            digits_seen = 0;
   int unsigned            items_sent = 0;
   int unsigned            items_total = 0;
   int unsigned            errors = 0;
   int unsigned            cycle_count = 0;

   integer_to_ascii_digits dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic add_number(input logic [63:0] value, input logic [2:0] opcode,
                             input logic [2:0] len_mode, input int gap, input bit hold);
      conv_item_type it;
      it.value    = value;
      it.opcode   = opcode;
      it.len_mode = len_mode;
      it.gap      = gap;
      it.hold     = hold;
      pending_numbers.push_back(it);
      items_total++;
   endtask

   // Cut, take magnitude if signed, then queue the digits most significant first.
   task automatic predict_digits(input conv_item_type it);
      int unsigned       width;
      logic [63:0]       mask;
      logic [63:0]       x;
      logic [63:0]       radix;
      logic [63:0]       rem;
      logic [CHAR_W-1:0] alpha;
      logic [CHAR_W-1:0] rev[$];
      digit_type         d;
      if (it.opcode > OPC_HEXU) return;
      case (it.len_mode)
         LEN_HH:         width = 8;
         LEN_H:          width = 16;
         LEN_L, LEN_LL:  width = 64;
         default:        width = 32;
      endcase
      mask = (width == 64) ? '1 : ((64'd1 << width) - 64'd1);
      x = it.value & mask;
      if (it.opcode == OPC_SDEC && x[width-1]) x = (~x + 64'd1) & mask;
      if (it.opcode == OPC_OCT) radix = 8;
      else if (it.opcode == OPC_HEXL || it.opcode == OPC_HEXU) radix = 16;
      else radix = 10;
      alpha = (it.opcode == OPC_HEXU) ? ASC_UPPER : ASC_LOWER;
      do begin
         rem = x % radix;
         x = x / radix;
         if (rem < 10) rev.push_front(ASC_ZERO + rem[CHAR_W-1:0]);
         else rev.push_front(alpha + rem[CHAR_W-1:0] - 7'd10);
      end while (x != 0);
      foreach (rev[k]) begin
         char_total = char_total + 1'b1;
         d.digit = rev[k];
         d.last  = (k == rev.size() - 1);
         d.count = char_total;
         digits_due.push_back(d);
         digits_predicted++;
      end
   endtask

   // Request driver
   always @(posedge clock) begin : req_driver
      conv_item_type cur;
      int            gap_left;
      bit            busy;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         gap_left = 0;
      end else begin
         busy = req_tvalid;
         if (req_tvalid && req_tready) begin
            predict_digits(cur);
            items_sent++;
            busy = 1'b0;
            gap_left = (pending_numbers.size() > 0) ? pending_numbers[0].gap : 0;
         end
         if (!busy) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_numbers.size() > 0 &&
                         (!pending_numbers[0].hold || digits_seen == digits_predicted)) begin
               cur = pending_numbers.pop_front();
               req_tdata <= {2'b00, cur.len_mode, cur.opcode, cur.value};
               busy = 1'b1;
            end
         end
         req_tvalid <= busy;
      end
   end

   // Result monitor and receiver back-pressure
   always @(posedge clock) begin : rsp_monitor
      digit_type want;
      int        stall_left;
      int        steady_left;
      int        r;
      bit        ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         steady_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (digits_due.size() == 0) begin
               $error("unexpected digit: digit_char %0d, chars_written %0d",
                      rsp_tdata[6:0], rsp_tdata[38:7]);
               errors++;
            end else begin
               want = digits_due.pop_front();
               digits_seen <= digits_seen + 1;
               if (rsp_tdata[6:0] !== want.digit) begin
                  $error("digit_char: expected %0d, got %0d", want.digit, rsp_tdata[6:0]);
                  errors++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_digit: expected %0d, got %0d", want.last, rsp_tlast);
                  errors++;
               end
               if (rsp_tdata[38:7] !== want.count) begin
                  $error("chars_written: expected %0d, got %0d", want.count, rsp_tdata[38:7]);
                  errors++;
               end
            end
         end
         if (steady_left > 0) begin
            steady_left--;
            ready_next = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 2) steady_left = $urandom_range(100, 300);
            else if (r < 40) stall_left = pick_gap();
            ready_next = (stall_left == 0);
         end
         rsp_tready <= ready_next;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : run_control
      int          converted;
      int          idx;
      logic [63:0] v;
      logic [2:0]  opc;
      logic [2:0]  len;
      int          gap;

      // directed: zeros, extremes, sign boundaries, every opcode and odd codes
      add_number(64'd0, OPC_UDEC, LEN_INT, 0, 1'b0);
      add_number('1, OPC_UDEC, LEN_LL, 0, 1'b0);
      add_number(64'hFFFF_FFFF_FFFF_FF00, OPC_UDEC, LEN_HH, 0, 1'b0);
      add_number('1, OPC_UDEC, LEN_H, 2, 1'b0);
      add_number(64'h1234_5678_FFFF_FF80, OPC_SDEC, LEN_HH, 0, 1'b0);
      add_number(64'h0000_0000_0000_8000, OPC_SDEC, LEN_H, 0, 1'b0);
      add_number(64'hFFFF_FFFF_8000_0000, OPC_SDEC, LEN_INT, 1, 1'b0);
      add_number(64'h8000_0000_0000_0000, OPC_SDEC, LEN_L, 0, 1'b0);
      add_number('1, OPC_SDEC, LEN_LL, 0, 1'b0);
      add_number(64'hFFFF_FFFF_FFFF_FF7F, OPC_SDEC, LEN_HH, 0, 1'b0);
      add_number('1, OPC_OCT, LEN_LL, 0, 1'b0);
      add_number(64'h0000_0000_0000_00FF, OPC_OCT, LEN_HH, 3, 1'b0);
      add_number(64'd0, OPC_OCT, LEN_INT, 0, 1'b0);
      add_number(64'hFEDC_BA98_7654_3210, OPC_HEXL, LEN_LL, 0, 1'b0);
      add_number(64'h0123_4567_89AB_CDEF, OPC_HEXU, LEN_L, 0, 1'b0);
      add_number(64'hFFFF_FFFF_FFFF_0000, OPC_HEXU, LEN_H, 0, 1'b0);
      add_number(64'hABCD_0000_DEAD_BEEF, OPC_HEXL, LEN_UNKNOWN_MIN, 0, 1'b0);
      add_number(64'h0000_0001_0000_0000, OPC_UDEC, 3'd6, 0, 1'b0);
      add_number(64'h0000_0000_FFFF_FFFF, OPC_SDEC, LEN_UNKNOWN_MAX, 0, 1'b0);
      for (int op = OPC_HEXU + 1; op <= OPC_UNKNOWN_MAX; op++)
         add_number('1, op[2:0], LEN_LL, 0, 1'b0);
      add_number(64'd9, OPC_UDEC, LEN_INT, 0, 1'b0);

      // random numbers; a steady stretch with no sender gaps in the middle
      converted = 0;
      idx = 0;
      while (converted < RANDOM_NUMBERS) begin
         case ($urandom_range(0, 5))
            0:       v = {$urandom, $urandom};
            1:       v = 64'($urandom_range(0, 999));
            2:       v = '1;
            3:       v = 64'd1 << $urandom_range(0, 63);
            4:       v = {$urandom, $urandom} >> $urandom_range(0, 63);
            default: v = ~(64'd1 << $urandom_range(0, 63));
         endcase
         if ($urandom_range(0, 9) == 0) opc = 3'($urandom_range(OPC_HEXU + 1, OPC_UNKNOWN_MAX));
         else opc = 3'($urandom_range(OPC_UDEC, OPC_HEXU));
         if ($urandom_range(0, 9) == 0)
            len = 3'($urandom_range(LEN_UNKNOWN_MIN, LEN_UNKNOWN_MAX));
         else len = 3'($urandom_range(LEN_INT, LEN_LL));
         gap = (idx >= 120 && idx < 160) ? 0 : pick_gap();
         add_number(v, opc, len, gap, idx == 0 || idx == 60 || $urandom_range(0, 39) == 0);
         if (opc <= OPC_HEXU) converted++;
         idx++;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (items_sent != items_total || digits_seen != digits_predicted);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (errors == 0 && digits_due.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
